// ===== hw/rtl/size_class_slot_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the size-class slot allocator
// Concurrent checks on clk with rst_n low disabling them; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define SIZE_CLASS_SLOT_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SCSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SCSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCSA_ASSERT_IMP(lbl, ante, cons, msg)
`define SCSA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/scsa_pkg.sv =====
// ----------------------------------------------------------------------------
// scsa_pkg
// Constants, types and the control store of the size-class slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package scsa_pkg;

  // Geometry
  localparam int PAGE_SHIFT     = 12;
  localparam int MIN_SLOT_SHIFT = 4;
  localparam int NUM_CLASSES    = 9;
  localparam int STACK_DEPTH    = 512;
  localparam int NUM_PAGES      = 1024;

  // Field widths of the channels
  localparam int ADDR_W     = 32;
  localparam int REQ_SIZE_W = 13;
  localparam int SPARE_W    = 10;
  localparam int STATUS_W   = 2;

  // Derived widths
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PAGE_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int REL_W   = PAGE_SHIFT + PAGE_W;
  localparam int STK_DEPTH_ALL = NUM_CLASSES * STACK_DEPTH;
  localparam int STK_AW  = (STK_DEPTH_ALL > 1) ? $clog2(STK_DEPTH_ALL) : 1;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_FULL      = 2'd2,
    ST_OUTSIDE   = 2'd3
  } status_t;

  // Sequencer steps (control store addresses)
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_CHK,
    S_ALLOC_HIT,
    S_REFILL,
    S_MAP_WR,
    S_FILL,
    S_POP_RD,
    S_POP_CAP,
    S_FREE_RD,
    S_FREE_CAP,
    S_FREE_CNT,
    S_FREE_CHK,
    S_PUSH,
    S_REPORT
  } step_t;

  // Datapath actions
  typedef enum logic [3:0] {
    A_NONE,
    A_ACCEPT,
    A_CNT_RD,
    A_CNT_FULL,
    A_REFILL,
    A_MAP_WR,
    A_FILL,
    A_POP_RD,
    A_POP_CAP,
    A_MAP_RD,
    A_MAP_CAP,
    A_PUSH,
    A_REPORT
  } act_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_FIRE,
    C_FREE,
    C_ERR,
    C_NONEMPTY,
    C_FILL_LAST,
    C_OUT_FREE
  } cond_t;

  // One control word: action, jump condition, hold-on-false, jump target
  typedef struct packed {
    act_t  act;
    cond_t cond;
    logic  hold;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic             fits;
    logic [CLS_W-1:0] cls;
  } cls_res_t;

  // Control store
  function automatic ctl_t ucode(input step_t s);
    ctl_t w;
    unique case (s)
      S_IDLE:      w = '{A_ACCEPT,   C_IN_FIRE,   1'b1, S_DISPATCH};
      S_DISPATCH:  w = '{A_CNT_RD,   C_FREE,      1'b0, S_FREE_RD};
      S_ALLOC_CHK: w = '{A_NONE,     C_ERR,       1'b0, S_REPORT};
      S_ALLOC_HIT: w = '{A_NONE,     C_NONEMPTY,  1'b0, S_POP_RD};
      S_REFILL:    w = '{A_REFILL,   C_NEVER,     1'b0, S_IDLE};
      S_MAP_WR:    w = '{A_MAP_WR,   C_ERR,       1'b0, S_REPORT};
      S_FILL:      w = '{A_FILL,     C_FILL_LAST, 1'b1, S_POP_RD};
      S_POP_RD:    w = '{A_POP_RD,   C_NEVER,     1'b0, S_IDLE};
      S_POP_CAP:   w = '{A_POP_CAP,  C_ALWAYS,    1'b0, S_REPORT};
      S_FREE_RD:   w = '{A_MAP_RD,   C_ERR,       1'b0, S_REPORT};
      S_FREE_CAP:  w = '{A_MAP_CAP,  C_NEVER,     1'b0, S_IDLE};
      S_FREE_CNT:  w = '{A_CNT_FULL, C_NEVER,     1'b0, S_IDLE};
      S_FREE_CHK:  w = '{A_NONE,     C_ERR,       1'b0, S_REPORT};
      S_PUSH:      w = '{A_PUSH,     C_ALWAYS,    1'b0, S_REPORT};
      S_REPORT:    w = '{A_REPORT,   C_OUT_FREE,  1'b1, S_IDLE};
      default:     w = '{A_NONE,     C_ALWAYS,    1'b0, S_IDLE};
    endcase
    return w;
  endfunction

  // Smallest class whose slot holds the size; fits is low when none does
  function automatic cls_res_t size_class(input logic [REQ_SIZE_W-1:0] size);
    cls_res_t r;
    r.fits = 1'b0;
    r.cls  = '0;
    if (33'(size) <= (33'd1 << PAGE_SHIFT)) begin
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
        if ((64'd1 << (MIN_SLOT_SHIFT + c)) >= 64'(size)) begin
          r.fits = 1'b1;
          r.cls  = CLS_W'(c);
        end
      end
    end
    return r;
  endfunction

  // Number of slots pushed by a refill of the class, capped at the stack depth
  function automatic logic [CNT_W-1:0] fill_count(input logic [CLS_W-1:0] cls);
    int sh;
    int n;
    sh = PAGE_SHIFT - MIN_SLOT_SHIFT - int'(cls);
    if (sh < 0) begin
      n = 1;
    end else if (sh >= 20) begin
      n = STACK_DEPTH;
    end else begin
      n = 1 << sh;
    end
    if (n > STACK_DEPTH) begin
      n = STACK_DEPTH;
    end
    return CNT_W'(n);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scsa_if.sv =====
// ----------------------------------------------------------------------------
// scsa_if
// Valid/ready channels of the allocator: request, result and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface scsa_in_if import scsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [REQ_SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0]     freed_address;
  logic [SPARE_W-1:0]    spare_page;

  modport source (output valid, req_type, request_size, freed_address, spare_page,
                  input ready);
  modport sink (input valid, req_type, request_size, freed_address, spare_page,
                output ready);
endinterface

interface scsa_out_if import scsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   slot_address;
  logic [STATUS_W-1:0] status;
  logic                page_taken;

  modport source (output valid, slot_address, status, page_taken, input ready);
  modport sink (input valid, slot_address, status, page_taken, output ready);
endinterface

interface scsa_cfg_if import scsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scsa_ram.sv =====
// ----------------------------------------------------------------------------
// scsa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module scsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/size_class_slot_allocator_top.sv =====
// An allocate from a non-empty stack runs dispatch, check, hit, stack read,
// capture and report; a free runs dispatch, page class read, capture, count
// read, check, push and report. A refill adds page setup and one write per slot
// (at most STACK_DEPTH) on the single stack write port; errors finish sooner.
// Reset (rst_n low, synchronous) empties all stacks and clears base_r;
// the stack and page-class memories need no clearing pass.
// ----------------------------------------------------------------------------
// size_class_slot_allocator_top
// Segregated free-list slab allocator driven by a microcoded step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "size_class_slot_allocator_top_macros.svh"

module size_class_slot_allocator_top import scsa_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  scsa_in_if.sink   in_bus,
  scsa_out_if.source out_bus,
  scsa_cfg_if.sink  cfg_bus
);

  // Sequencer
  step_t upc_r, upc_nxt;
  ctl_t  ctl;
  logic  cond_hit;

  // Datapath registers
  logic [ADDR_W-1:0]  base_r;
  logic               req_r;
  logic [SPARE_W-1:0] spare_r;
  logic [REL_W-1:0]   rel_r;
  logic [CLS_W-1:0]   cls_r;
  logic [CNT_W-1:0]   cnt_r;
  status_t            err_r;
  logic               taken_r;
  logic [ADDR_W-1:0]  res_addr_r;
  logic [IDX_W-1:0]   fill_i_r;
  logic [CNT_W-1:0]   fill_n_r;
  logic [REL_W-1:0]   fill_off_r;
  logic [CNT_W-1:0]   counts_r [NUM_CLASSES];

  // Result register
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  status_t           out_status_r;
  logic              out_taken_r;

  // Combinational helpers
  logic              in_fire;
  logic              out_free;
  cls_res_t          cls_res;
  logic [ADDR_W:0]   diff;
  logic              outside;
  logic [CNT_W-1:0]  cnt_sel;
  logic [REL_W-1:0]  slot_step;
  logic [CNT_W-1:0]  cnt_dec;

  // Memory ports
  logic              stk_we;
  logic [STK_AW-1:0] stk_waddr;
  logic [REL_W-1:0]  stk_wdata;
  logic              stk_re;
  logic [STK_AW-1:0] stk_raddr;
  logic [REL_W-1:0]  stk_rdata;
  logic              map_we;
  logic              map_re;
  logic [CLS_W-1:0]  map_rdata;

  // Control word fetch and handshakes
  assign ctl          = ucode(upc_r);
  assign in_bus.ready = (ctl.act == A_ACCEPT);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;
  assign cfg_bus.ready = 1'b1;

  // Request decode
  assign cls_res = size_class(in_bus.request_size);
  assign diff    = {1'b0, in_bus.freed_address} - {1'b0, base_r};
  assign outside = diff[ADDR_W] ||
                   (33'(diff[ADDR_W-1:PAGE_SHIFT]) >= 33'(NUM_PAGES));

  assign cnt_sel   = (cls_r < CLS_W'(NUM_CLASSES)) ? counts_r[cls_r] : '0;
  assign slot_step = REL_W'(1) << (MIN_SLOT_SHIFT + int'(cls_r));
  assign cnt_dec   = cnt_r - CNT_W'(1);

  // Evaluate the jump condition and pick the next step
  always_comb begin
    unique case (ctl.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_IN_FIRE:   cond_hit = in_fire;
      C_FREE:      cond_hit = req_r;
      C_ERR:       cond_hit = (err_r != ST_OK);
      C_NONEMPTY:  cond_hit = (cnt_r != '0);
      C_FILL_LAST: cond_hit = ((CNT_W'(fill_i_r) + CNT_W'(1)) == fill_n_r);
      C_OUT_FREE:  cond_hit = out_free;
      default:     cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      upc_nxt = ctl.target;
    end else if (ctl.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = step_t'(4'(upc_r) + 4'd1);
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      base_r <= cfg_bus.data;
    end
  end

  // Datapath: carry out the action of the current control word
  always_ff @(posedge clk) begin
    case (ctl.act)
      A_ACCEPT: begin
        if (in_fire) begin
          req_r      <= in_bus.req_type;
          spare_r    <= in_bus.spare_page;
          rel_r      <= diff[REL_W-1:0];
          taken_r    <= 1'b0;
          res_addr_r <= '0;
          if (!in_bus.req_type) begin
            cls_r <= cls_res.fits ? cls_res.cls : '0;
            err_r <= cls_res.fits ? ST_OK : ST_TOO_LARGE;
          end else begin
            cls_r <= '0;
            err_r <= outside ? ST_OUTSIDE : ST_OK;
          end
        end
      end
      A_CNT_RD: begin
        cnt_r <= cnt_sel;
      end
      A_CNT_FULL: begin
        cnt_r <= cnt_sel;
        if (cnt_sel == CNT_W'(STACK_DEPTH)) begin
          err_r <= ST_FULL;
        end
      end
      A_REFILL: begin
        fill_i_r   <= '0;
        fill_n_r   <= fill_count(cls_r);
        fill_off_r <= REL_W'(spare_r) << PAGE_SHIFT;
        if (32'(spare_r) >= 32'(NUM_PAGES)) begin
          err_r <= ST_OUTSIDE;
        end
      end
      A_MAP_WR: begin
        taken_r <= (err_r == ST_OK);
      end
      A_FILL: begin
        fill_i_r   <= fill_i_r + IDX_W'(1);
        fill_off_r <= fill_off_r + slot_step;
        cnt_r      <= CNT_W'(fill_i_r) + CNT_W'(1);
      end
      A_POP_CAP: begin
        res_addr_r <= base_r + ADDR_W'(stk_rdata);
      end
      A_MAP_CAP: begin
        cls_r <= (map_rdata < CLS_W'(NUM_CLASSES)) ? map_rdata : '0;
      end
      default: begin
      end
    endcase
  end

  // Entry counts: pop on allocate, push on free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        counts_r[c] <= '0;
      end
    end else if (ctl.act == A_POP_RD) begin
      counts_r[cls_r] <= cnt_dec;
    end else if (ctl.act == A_PUSH) begin
      counts_r[cls_r] <= cnt_r + CNT_W'(1);
    end
  end

  // Result register: load on report, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.act == A_REPORT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.act == A_REPORT && out_free) begin
      out_addr_r   <= (err_r == ST_OK) ? res_addr_r : '0;
      out_status_r <= err_r;
      out_taken_r  <= taken_r;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.slot_address = out_addr_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.page_taken   = out_taken_r;

  // Slot stack memory: class-major, one stack of STACK_DEPTH per class
  always_comb begin
    stk_we    = (ctl.act == A_FILL) || (ctl.act == A_PUSH);
    stk_waddr = STK_AW'(cls_r) * STK_AW'(STACK_DEPTH) +
                STK_AW'((ctl.act == A_FILL) ? fill_i_r : cnt_r[IDX_W-1:0]);
    stk_wdata = (ctl.act == A_FILL) ? fill_off_r : rel_r;
    stk_re    = (ctl.act == A_POP_RD);
    stk_raddr = STK_AW'(cls_r) * STK_AW'(STACK_DEPTH) + STK_AW'(cnt_dec[IDX_W-1:0]);
  end

  scsa_ram #(
    .WIDTH (REL_W),
    .DEPTH (STK_DEPTH_ALL)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Page class memory: written by a refill, read by a free
  assign map_we = (ctl.act == A_MAP_WR) && (err_r == ST_OK);
  assign map_re = (ctl.act == A_MAP_RD);

  scsa_ram #(
    .WIDTH (CLS_W),
    .DEPTH (NUM_PAGES)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (PAGE_W'(spare_r)),
    .wdata (cls_r),
    .re    (map_re),
    .raddr (rel_r[REL_W-1:PAGE_SHIFT]),
    .rdata (map_rdata)
  );

  // Checks
  `SCSA_ASSERT_NXT(a_accept_dispatch, in_fire, upc_r == S_DISPATCH,
                   "request transfer not followed by dispatch")
  `SCSA_ASSERT_IMP(a_pop_nonempty, ctl.act == A_POP_RD, cnt_r != '0,
                   "pop from an empty stack")
  `SCSA_ASSERT_IMP(a_push_room, ctl.act == A_PUSH, cnt_r < CNT_W'(STACK_DEPTH),
                   "push onto a full stack")
  `SCSA_ASSERT_IMP(a_err_zero_addr, out_bus.valid && out_bus.status != ST_OK,
                   out_bus.slot_address == '0 && !out_bus.page_taken,
                   "error result carries an address or a taken page")

endmodule

`default_nettype wire

// ===== tb/sv/size_class_slot_allocator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Size-class slot allocator testbench
// Drives allocate and free requests through the request channel, predicts
// every result from a behavioral copy of the size-class stacks and the page
// class map, and checks each result field by field in order. Region base is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module size_class_slot_allocator_top_tb;
  import scsa_pkg::*;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;
  localparam int   PAGE_BYTES   = 1 << PAGE_SHIFT;
  localparam int   MAX_GAP      = 18;
  localparam int   HOLD_CYCLES  = 400;
  localparam int   STALL_LIMIT  = 4000;
  localparam int   TAIL_CYCLES  = 40;
  localparam int   REPORT_LIMIT = 10;
  localparam int   TOTAL_ITEMS  = 2000;

  typedef struct packed {
    logic                  req_type;
    logic [REQ_SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0]     freed_address;
    logic [SPARE_W-1:0]    spare_page;
  } slot_request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] slot_address;
    status_t           status;
    logic              page_taken;
  } slot_result_t;

  logic clk;
  logic rst_n;

  scsa_in_if  in_ch ();
  scsa_out_if out_ch ();
  scsa_cfg_if cfg_ch ();

  size_class_slot_allocator_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  // Allocator shadow state
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] free_slots [NUM_CLASSES][STACK_DEPTH];
  int unsigned       slot_count [NUM_CLASSES];
  logic [3:0]        page_class [NUM_PAGES];
  bit                page_owned [NUM_PAGES];
  logic [ADDR_W-1:0] live_slots [$];

  slot_request_t request_queue [$];
  slot_result_t  expected_results [$];
  slot_request_t offered;

  int unsigned items_queued;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int          send_gap_left;
  int          recv_stall_left;
  bit          send_gaps;
  bit          recv_gaps;
  logic        long_hold;

  // Apply one request to the shadow state and return the result it gives
  function automatic slot_result_t allocator_outcome(input slot_request_t r);
    slot_result_t      res;
    int unsigned       cls;
    int unsigned       nslots;
    int unsigned       i;
    logic [ADDR_W-1:0] rel;
    logic [ADDR_W-1:0] page_no;
    res.slot_address = '0;
    res.status       = ST_OK;
    res.page_taken   = 1'b0;
    if (r.req_type == REQ_ALLOC) begin
      if (r.request_size > PAGE_BYTES) begin
        res.status = ST_TOO_LARGE;
        return res;
      end
      cls = 0;
      while (cls < NUM_CLASSES && (64'd1 << (MIN_SLOT_SHIFT + cls)) < r.request_size)
        cls++;
      if (cls >= NUM_CLASSES) begin
        res.status = ST_TOO_LARGE;
        return res;
      end
      // Refill an empty class from the spare page
      if (slot_count[cls] == 0) begin
        if (r.spare_page >= NUM_PAGES) begin
          res.status = ST_OUTSIDE;
          return res;
        end
        nslots = 1 << (PAGE_SHIFT - MIN_SLOT_SHIFT - cls);
        if (nslots > STACK_DEPTH) nslots = STACK_DEPTH;
        for (i = 0; i < nslots; i++)
          free_slots[cls][i] = (ADDR_W'(r.spare_page) << PAGE_SHIFT) +
                               ADDR_W'(i << (MIN_SLOT_SHIFT + cls));
        slot_count[cls] = nslots;
        page_class[r.spare_page] = 4'(cls);
        page_owned[r.spare_page] = 1'b1;
        res.page_taken = 1'b1;
      end
      slot_count[cls]--;
      rel = free_slots[cls][slot_count[cls]];
      res.slot_address = base_addr + rel;
      if (live_slots.size() < 4000) live_slots.push_back(rel);
      return res;
    end
    // Free: locate the page, then push onto its class stack
    if (r.freed_address < base_addr) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    rel = r.freed_address - base_addr;
    page_no = rel >> PAGE_SHIFT;
    if (page_no >= NUM_PAGES) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    cls = 32'(page_class[page_no]);
    if (cls >= NUM_CLASSES) cls = 0;
    if (slot_count[cls] >= STACK_DEPTH) begin
      res.status = ST_FULL;
      return res;
    end
    free_slots[cls][slot_count[cls]] = rel;
    slot_count[cls]++;
    return res;
  endfunction

  function automatic void queue_alloc(input logic [REQ_SIZE_W-1:0] size,
                                      input logic [SPARE_W-1:0] spare);
    slot_request_t r;
    r.req_type      = REQ_ALLOC;
    r.request_size  = size;
    r.freed_address = $urandom;
    r.spare_page    = spare;
    request_queue.push_back(r);
    items_queued++;
  endfunction

  function automatic void queue_free(input logic [ADDR_W-1:0] addr);
    slot_request_t r;
    r.req_type      = REQ_FREE;
    r.request_size  = REQ_SIZE_W'($urandom_range(0, (1 << REQ_SIZE_W) - 1));
    r.freed_address = addr;
    r.spare_page    = SPARE_W'($urandom_range(0, (1 << SPARE_W) - 1));
    request_queue.push_back(r);
    items_queued++;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Request driver: hold an offered item until its transfer, then draw a gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(allocator_outcome(offered));
        send_gap_left = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap_left > 0) begin
          send_gap_left--;
          in_ch.valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          offered = request_queue.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.req_type      <= offered.req_type;
          in_ch.request_size  <= offered.request_size;
          in_ch.freed_address <= offered.freed_address;
          in_ch.spare_page    <= offered.spare_page;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest expectation, then draw a stall
  always @(posedge clk) begin
    slot_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected result: addr %h status %0d taken %b",
                     out_ch.slot_address, out_ch.status, out_ch.page_taken);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.slot_address !== want.slot_address || out_ch.status !== want.status ||
              out_ch.page_taken !== want.page_taken) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"result %0d: expected addr %h status %0d taken %b, ",
                        "got addr %h status %0d taken %b"},
                       results_seen, want.slot_address, want.status, want.page_taken,
                       out_ch.slot_address, out_ch.status, out_ch.page_taken);
          end
        end
        recv_stall_left = recv_gaps ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (recv_stall_left > 0) begin
        recv_stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !long_hold;
      end
    end
  end

  // Watchdog: end the run when no channel has moved for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Long receiver hold-off while requests keep coming, to back up the block
  initial begin
    long_hold = 1'b0;
    while (results_seen < 300 || request_queue.size() < 20) @(negedge clk);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic write_base(input logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    base_addr = value;
  endtask

  // Wait until every queued request has been answered
  task automatic settle();
    while (request_queue.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Mostly allocate/free traffic on live slots, with some noise
  task automatic mixed_phase(input int unsigned n_items);
    logic [ADDR_W-1:0]     owned [$];
    logic [ADDR_W-1:0]     addr;
    logic [ADDR_W-1:0]     rel;
    logic [REQ_SIZE_W-1:0] size;
    int unsigned           p;
    int unsigned           pick;
    int unsigned           k;
    for (p = 0; p < NUM_PAGES; p++)
      if (page_owned[p]) owned.push_back(p);
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 7) == 0)
          size = REQ_SIZE_W'((1 << $urandom_range(MIN_SLOT_SHIFT, PAGE_SHIFT)) +
                             $urandom_range(0, 1));
        else
          size = REQ_SIZE_W'($urandom_range(0, 1 << $urandom_range(3, PAGE_SHIFT)));
        queue_alloc(size, SPARE_W'($urandom_range(0, (1 << SPARE_W) - 1)));
      end else if (pick < 60) begin
        queue_alloc(REQ_SIZE_W'($urandom_range(PAGE_BYTES + 1, (1 << REQ_SIZE_W) - 1)),
                    SPARE_W'($urandom_range(0, (1 << SPARE_W) - 1)));
      end else if (pick < 85 && live_slots.size() != 0) begin
        p = $urandom_range(0, live_slots.size() - 1);
        queue_free(base_addr + live_slots[p]);
        live_slots.delete(p);
      end else if (pick < 93 && owned.size() != 0) begin
        queue_free(base_addr + (owned[$urandom_range(0, owned.size() - 1)] << PAGE_SHIFT) +
                   $urandom_range(0, PAGE_BYTES - 1));
      end else begin
        // Stray address: anywhere except a page inside the region never refilled
        do begin
          addr = $urandom;
          rel  = addr - base_addr;
        end while (addr >= base_addr && (rel >> PAGE_SHIFT) < NUM_PAGES &&
                   !page_owned[rel >> PAGE_SHIFT]);
        queue_free(addr);
      end
    end
  endtask

  // Push one class stack past full with frees inside a single owned page
  task automatic fill_phase();
    logic [ADDR_W-1:0] owned [$];
    int unsigned       p;
    int unsigned       cls;
    int unsigned       n;
    for (p = 0; p < NUM_PAGES; p++)
      if (page_owned[p]) owned.push_back(p);
    p   = owned[$urandom_range(0, owned.size() - 1)];
    cls = 32'(page_class[p]);
    n   = STACK_DEPTH - slot_count[cls] + 3;
    repeat (n) queue_free(base_addr + (p << PAGE_SHIFT) + $urandom_range(0, PAGE_BYTES - 1));
  endtask

  initial begin
    int unsigned phase_no;
    logic [ADDR_W-1:0] next_base;

    // Known values on every input from time zero
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.req_type      = REQ_ALLOC;
    in_ch.request_size  = '0;
    in_ch.freed_address = '0;
    in_ch.spare_page    = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    base_addr           = '0;
    send_gaps           = 1'b0;
    recv_gaps           = 1'b0;
    items_queued        = 0;
    results_seen        = 0;
    fail_count          = 0;
    quiet_cycles        = 0;
    for (int c = 0; c < NUM_CLASSES; c++) slot_count[c] = 0;
    for (int p = 0; p < NUM_PAGES; p++) begin
      page_class[p] = '0;
      page_owned[p] = 1'b0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: refills, hits, every class, oversize, region edges, frees.
    // A spare page beyond the region cannot be expressed in the 10-bit field.
    write_base('0);
    @(negedge clk);
    queue_alloc(0, 5);
    queue_alloc(16, 6);
    queue_alloc(17, 7);
    queue_alloc(4096, 1023);
    queue_alloc(4096, 0);
    queue_alloc(4097, 9);
    queue_alloc(8191, 9);
    queue_alloc(32, 10);
    queue_alloc(64, 11);
    queue_alloc(128, 12);
    queue_alloc(256, 13);
    queue_alloc(512, 14);
    queue_alloc(1024, 15);
    queue_alloc(2048, 16);
    queue_alloc(2000, 17);
    queue_free(ADDR_W'(NUM_PAGES) << PAGE_SHIFT);
    queue_free('1);
    queue_free((5 << PAGE_SHIFT) | 16);
    queue_free((5 << PAGE_SHIFT) | 7);
    queue_free((5 << PAGE_SHIFT) | 7);
    queue_free((1023 << PAGE_SHIFT) | (PAGE_BYTES - 1));
    queue_alloc(3000, 20);
    settle();

    // Region at the top of the address space: below-region free and wrap
    write_base(32'hFFFF_F000);
    @(negedge clk);
    queue_free(32'hFFFF_EFFF);
    queue_free(32'hFFFF_F010);
    queue_alloc(1, 30);
    queue_alloc(4096, 31);
    settle();

    // Random phases
    phase_no = 0;
    while (items_queued < TOTAL_ITEMS) begin
      case (phase_no)
        0: write_base(32'hFFC0_0000);
        1: write_base(32'hFFFF_FFFF);
        2: write_base('0);
        5: write_base(32'h0010_0000);
        default: begin
          if ($urandom_range(0, 2) == 0) begin
            next_base = $urandom;
            if ($urandom_range(0, 1) == 0) next_base[PAGE_SHIFT-1:0] = '0;
            write_base(next_base);
          end
        end
      endcase
      @(negedge clk);
      send_gaps = $urandom_range(0, 2) != 0;
      recv_gaps = $urandom_range(0, 2) != 0;
      if (phase_no == 5)
        fill_phase();
      else
        mixed_phase($urandom_range(60, 150));
      settle();
      phase_no++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
